### design/ims_pkg.sv
// Shared constants and types for the Ising Metropolis spin update block.
package ims_pkg;

  localparam int GRID_SIZE_DEF = 64;

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int COORD_W = 6;
  localparam int FRAC_W  = 16;
  localparam int DE_W    = 5;
  localparam int CFG_W   = 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_FLIP  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_W-1:0] CFG_ACCEPT_FOUR  = 1'b0;
  localparam logic [CFG_W-1:0] CFG_ACCEPT_EIGHT = 1'b1;

  localparam logic [FRAC_W-1:0] ACCEPT_FOUR_RST  = 16'd11246;
  localparam logic [FRAC_W-1:0] ACCEPT_EIGHT_RST = 16'd1929;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic                   spin;
    logic                   flipped;
    logic signed [DE_W-1:0] energy_change;
  } ims_result_t;

endpackage

### design/ims_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
module ims_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### design/ims_addr.sv
// Site decode: wraps row and column onto the torus and finds the four neighbors.
module ims_addr #(
  parameter int GRID_SIZE = ims_pkg::GRID_SIZE_DEF
) (
  input  logic [ims_pkg::COORD_W-1:0]   row,
  input  logic [ims_pkg::COORD_W-1:0]   col,
  output logic [$clog2(GRID_SIZE)-1:0] r,
  output logic [$clog2(GRID_SIZE)-1:0] c,
  output logic [$clog2(GRID_SIZE)-1:0] r_up,
  output logic [$clog2(GRID_SIZE)-1:0] r_dn,
  output logic [$clog2(GRID_SIZE)-1:0] c_lf,
  output logic [$clog2(GRID_SIZE)-1:0] c_rt
);
  import ims_pkg::*;

  localparam int IDX_W = $clog2(GRID_SIZE);
  localparam int RAW_N = 1 << COORD_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(GRID_SIZE - 1);

  // Constant reduction table: raw coordinate modulo grid size
  logic [IDX_W-1:0] wrap_tbl [RAW_N];

  for (genvar i = 0; i < RAW_N; i++) begin : g_wrap
    assign wrap_tbl[i] = IDX_W'(i % GRID_SIZE);
  end

  assign r = wrap_tbl[row];
  assign c = wrap_tbl[col];

  assign r_up = (r == '0)   ? LAST : r - 1'b1;
  assign r_dn = (r == LAST) ? '0   : r + 1'b1;
  assign c_lf = (c == '0)   ? LAST : c - 1'b1;
  assign c_rt = (c == LAST) ? '0   : c + 1'b1;

endmodule

### design/ims_eval.sv
// Spin evaluation: energy change, Metropolis acceptance and the updated row.
module ims_eval #(
  parameter int GRID_SIZE = ims_pkg::GRID_SIZE_DEF
) (
  input  logic [GRID_SIZE-1:0]          ctr_row,
  input  logic [GRID_SIZE-1:0]          up_row,
  input  logic [GRID_SIZE-1:0]          dn_row,
  input  logic [$clog2(GRID_SIZE)-1:0]  c,
  input  logic [$clog2(GRID_SIZE)-1:0]  c_lf,
  input  logic [$clog2(GRID_SIZE)-1:0]  c_rt,
  input  logic [ims_pkg::OP_W-1:0]      op,
  input  logic                          spin_value,
  input  logic [ims_pkg::FRAC_W-1:0]    random_fraction,
  input  logic [ims_pkg::FRAC_W-1:0]    accept_four,
  input  logic [ims_pkg::FRAC_W-1:0]    accept_eight,
  output logic                          we,
  output logic [GRID_SIZE-1:0]          new_row,
  output ims_pkg::ims_result_t          result
);
  import ims_pkg::*;

  logic       s;
  logic [2:0] agree;
  logic       accept;
  logic       new_bit;

  // Neighbors that agree with the center: dE = 4*agree - 8
  always_comb begin
    s = ctr_row[c];
    agree = 3'(up_row[c] == s) + 3'(dn_row[c] == s)
          + 3'(ctr_row[c_lf] == s) + 3'(ctr_row[c_rt] == s);
    case (agree) inside
      3'd0, 3'd1, 3'd2: accept = 1'b1;
      3'd3:             accept = random_fraction < accept_four;
      3'd4:             accept = random_fraction < accept_eight;
      default:          accept = 1'b0;
    endcase
  end

  always_comb begin
    we = 1'b0;
    new_bit = s;
    result.flipped = 1'b0;
    result.energy_change = '0;
    unique case (op)
      OP_WRITE: begin
        we = 1'b1;
        new_bit = spin_value;
      end
      OP_FLIP: begin
        we = accept;
        new_bit = ~s;
        result.flipped = accept;
        result.energy_change = DE_W'({agree, 2'b00}) - DE_W'(8);
      end
      default: begin
        // read and the unused code leave the grid alone
      end
    endcase
    result.spin = we ? new_bit : s;
    new_row = ctr_row;
    new_row[c] = new_bit;
  end

endmodule

### design/ising_metropolis_spin_update.sv
// Ising 2D torus Metropolis spin update. Spins are kept one row per word in two
// identical row memories: one gives the rows above and below, the other the
// addressed row with its left and right neighbors. A request is read in the
// cycle it is accepted and evaluated and written back in the next, unless it
// stalls; a new request is taken only once the last one is written back. The
// result sits in an output register; a new request is taken while it waits,
// and the block stalls in its execute state only if the previous result is
// still not taken. After reset a clearing pass sets every spin to -1; no
// request is taken during it. Configuration writes are registered and take
// effect in the next cycle.
module ising_metropolis_spin_update #(
  parameter int GRID_SIZE = ims_pkg::GRID_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ims_pkg::OP_W-1:0]           op,
  input  logic [ims_pkg::COORD_W-1:0]        row,
  input  logic [ims_pkg::COORD_W-1:0]        col,
  input  logic                               spin_value,
  input  logic [ims_pkg::FRAC_W-1:0]         random_fraction,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               spin,
  output logic                               flipped,
  output logic signed [ims_pkg::DE_W-1:0]    energy_change,
  input  logic                               cfg_we,
  input  logic [ims_pkg::CFG_W-1:0]          cfg_index,
  input  logic [ims_pkg::FRAC_W-1:0]         cfg_data
);
  import ims_pkg::*;

  localparam int IDX_W = $clog2(GRID_SIZE);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(GRID_SIZE - 1);

  state_t state, state_next;

  logic [IDX_W-1:0]   clr_row;
  logic [FRAC_W-1:0]  accept_four;
  logic [FRAC_W-1:0]  accept_eight;

  // Held request
  logic [COORD_W-1:0] hold_row;
  logic [COORD_W-1:0] hold_col;
  logic [OP_W-1:0]    hold_op;
  logic               hold_spin_value;
  logic [FRAC_W-1:0]  hold_rnd;

  logic               accept_req;
  logic               fire;
  logic               live_addr;
  logic [COORD_W-1:0] row_sel;
  logic [COORD_W-1:0] col_sel;

  logic [IDX_W-1:0]   r, c, r_up, r_dn, c_lf, c_rt;
  logic [GRID_SIZE-1:0] up_row, dn_row, ctr_row, new_row;

  logic               eval_we;
  ims_result_t        eval_res;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [GRID_SIZE-1:0] mem_wdata;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_row == LAST) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_EXEC;
      ST_EXEC:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready   = (state == ST_IDLE);
    accept_req = (state == ST_IDLE) && in_valid;
    fire       = (state == ST_EXEC) && (!out_valid || out_ready);
    live_addr  = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_row <= '0;
      out_valid <= 1'b0;
      accept_four <= ACCEPT_FOUR_RST;
      accept_eight <= ACCEPT_EIGHT_RST;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_row <= clr_row + 1'b1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ACCEPT_FOUR:  accept_four <= cfg_data;
          CFG_ACCEPT_EIGHT: accept_eight <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_req) begin
      hold_row <= row;
      hold_col <= col;
      hold_op <= op;
      hold_spin_value <= spin_value;
      hold_rnd <= random_fraction;
    end
    if (fire) begin
      spin <= eval_res.spin;
      flipped <= eval_res.flipped;
      energy_change <= eval_res.energy_change;
    end
  end

  // Reads are issued from the live request when idle, from the held one otherwise
  assign row_sel = live_addr ? row : hold_row;
  assign col_sel = live_addr ? col : hold_col;

  ims_addr #(.GRID_SIZE(GRID_SIZE)) u_addr (
    .row  (row_sel),
    .col  (col_sel),
    .r    (r),
    .c    (c),
    .r_up (r_up),
    .r_dn (r_dn),
    .c_lf (c_lf),
    .c_rt (c_rt)
  );

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_row;
      mem_wdata = '0;
    end else begin
      mem_we    = fire && eval_we;
      mem_waddr = r;
      mem_wdata = new_row;
    end
  end

  // Row copy for the rows above and below
  ims_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_nbr_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (r_up),
    .raddr_b (r_dn),
    .rdata_a (up_row),
    .rdata_b (dn_row)
  );

  // Row copy for the addressed row
  ims_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_ctr_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (r),
    .raddr_b (r),
    .rdata_a (ctr_row),
    .rdata_b ()
  );

  ims_eval #(.GRID_SIZE(GRID_SIZE)) u_eval (
    .ctr_row         (ctr_row),
    .up_row          (up_row),
    .dn_row          (dn_row),
    .c               (c),
    .c_lf            (c_lf),
    .c_rt            (c_rt),
    .op              (hold_op),
    .spin_value      (hold_spin_value),
    .random_fraction (hold_rnd),
    .accept_four     (accept_four),
    .accept_eight    (accept_eight),
    .we              (eval_we),
    .new_row         (new_row),
    .result          (eval_res)
  );

endmodule

### tb/ising_metropolis_spin_update_test.sv
// Self-checking testbench for the Ising torus Metropolis spin update block.
`timescale 1ns / 1ps

module ising_metropolis_spin_update_test;
  import ims_pkg::*;

  localparam int N = GRID_SIZE_DEF;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int REPORT_MAX = 10;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [OP_W-1:0] op;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic spin_value;
  logic [FRAC_W-1:0] random_fraction;
  logic out_valid;
  logic out_ready;
  logic spin;
  logic flipped;
  logic signed [DE_W-1:0] energy_change;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_index;
  logic [FRAC_W-1:0] cfg_data;

  // local copy of the torus and thresholds
  logic torus_model [0:N-1][0:N-1];
  logic [FRAC_W-1:0] accept_four_model = ACCEPT_FOUR_RST;
  logic [FRAC_W-1:0] accept_eight_model = ACCEPT_EIGHT_RST;

  ims_result_t pending_spin_results[$];

  bit steady_flow;
  int mismatches;
  int results_seen;
  int requests_seen;
  int flips_accepted;
  int de_count [0:4];
  int idle_cycles;

  ising_metropolis_spin_update i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .row(row),
    .col(col),
    .spin_value(spin_value),
    .random_fraction(random_fraction),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .spin(spin),
    .flipped(flipped),
    .energy_change(energy_change),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int spin_sign(logic b);
    return b ? 1 : -1;
  endfunction

  // Mostly no gap, some short, a few long; none while steady.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic ims_result_t apply_spin_update(logic [OP_W-1:0] rq_op,
                                                    logic [COORD_W-1:0] r,
                                                    logic [COORD_W-1:0] c,
                                                    logic sv,
                                                    logic [FRAC_W-1:0] frac);
    ims_result_t res;
    int ri;
    int ci;
    int nsum;
    int de;
    logic accept;
    ri = r % N;
    ci = c % N;
    res.flipped = 1'b0;
    res.energy_change = '0;
    case (rq_op)
      OP_WRITE: begin
        torus_model[ri][ci] = sv;
      end
      OP_FLIP: begin
        nsum = spin_sign(torus_model[(ri + N - 1) % N][ci])
             + spin_sign(torus_model[(ri + 1) % N][ci])
             + spin_sign(torus_model[ri][(ci + N - 1) % N])
             + spin_sign(torus_model[ri][(ci + 1) % N]);
        de = 2 * spin_sign(torus_model[ri][ci]) * nsum;
        if (de <= 0) accept = 1'b1;
        else if (de == 4) accept = frac < accept_four_model;
        else accept = frac < accept_eight_model;
        if (accept) begin
          torus_model[ri][ci] = ~torus_model[ri][ci];
          res.flipped = 1'b1;
          flips_accepted++;
        end
        res.energy_change = de[DE_W-1:0];
        de_count[(de + 8) / 4]++;
      end
      default: ;
    endcase
    res.spin = torus_model[ri][ci];
    return res;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  // Predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    ims_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_spin_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: spin %0b flipped %0b dE %0d",
                                spin, flipped, energy_change));
      end else begin
        want = pending_spin_results.pop_front();
        if (spin !== want.spin || flipped !== want.flipped ||
            energy_change !== want.energy_change)
          note_mismatch($sformatf("expected spin %0b flipped %0b dE %0d, got %0b %0b %0d",
                                  want.spin, want.flipped, want.energy_change,
                                  spin, flipped, energy_change));
      end
    end
    if (!rst && in_valid && in_ready) begin
      requests_seen++;
      pending_spin_results.push_back(apply_spin_update(op, row, col, spin_value,
                                                       random_fraction));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
        $display("ising_metropolis_spin_update_test: done, errors");
        $finish;
      end
    end
  end

  // Result side back-pressure, stalls start at any cycle.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Returns at the rising edge where the request was taken; valid stays up.
  task automatic send_request(logic [OP_W-1:0] rq_op, logic [COORD_W-1:0] r,
                              logic [COORD_W-1:0] c, logic sv,
                              logic [FRAC_W-1:0] frac);
    int gap;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op = rq_op;
    row = r;
    col = c;
    spin_value = sv;
    random_fraction = frac;
    in_valid = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_spin_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_thresholds(logic [FRAC_W-1:0] four, logic [FRAC_W-1:0] eight);
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = CFG_ACCEPT_FOUR;
    cfg_data = four;
    accept_four_model = four;
    @(negedge clk);
    cfg_index = CFG_ACCEPT_EIGHT;
    cfg_data = eight;
    accept_eight_model = eight;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Cold grid: every neighbor sum is -4, so flips see dE 8, then -8.
  task automatic test_cold_start();
    send_request(OP_READ, 6'd0, 6'd0, 1'b0, 16'h0000);
    send_request(OP_SPARE, 6'd63, 6'd63, 1'b1, 16'hFFFF);
    send_request(OP_FLIP, 6'd10, 6'd10, 1'b0, accept_eight_model);
    send_request(OP_FLIP, 6'd10, 6'd10, 1'b1, 16'h0000);
    send_request(OP_FLIP, 6'd10, 6'd10, 1'b0, 16'hFFFF);
    send_request(OP_READ, 6'd10, 6'd10, 1'b0, 16'h0000);
  endtask

  // Build neighborhoods for dE 0, 4 (equal and just below threshold), -4.
  task automatic test_energy_levels();
    send_request(OP_WRITE, 6'd19, 6'd20, 1'b1, 16'h0000);
    send_request(OP_WRITE, 6'd21, 6'd20, 1'b1, 16'h0000);
    send_request(OP_FLIP, 6'd20, 6'd20, 1'b0, 16'hFFFF);
    send_request(OP_WRITE, 6'd20, 6'd19, 1'b1, 16'h0000);
    send_request(OP_FLIP, 6'd20, 6'd20, 1'b0, accept_four_model);
    send_request(OP_FLIP, 6'd20, 6'd20, 1'b0, accept_four_model - 16'd1);
    send_request(OP_FLIP, 6'd20, 6'd20, 1'b0, 16'hFFFF);
  endtask

  // Neighbors of the corner site sit across both seams.
  task automatic test_torus_wrap();
    send_request(OP_WRITE, 6'd63, 6'd0, 1'b1, 16'h0000);
    send_request(OP_WRITE, 6'd0, 6'd63, 1'b1, 16'h0000);
    send_request(OP_WRITE, 6'd1, 6'd0, 1'b1, 16'h0000);
    send_request(OP_WRITE, 6'd0, 6'd1, 1'b1, 16'h0000);
    send_request(OP_FLIP, 6'd0, 6'd0, 1'b0, 16'hFFFF);
  endtask

  task automatic test_threshold_extremes();
    set_thresholds(16'h0000, 16'h0000);
    send_request(OP_FLIP, 6'd40, 6'd40, 1'b0, 16'h0000);
    set_thresholds(16'hFFFF, 16'hFFFF);
    send_request(OP_FLIP, 6'd40, 6'd40, 1'b0, 16'hFFFF);
    send_request(OP_FLIP, 6'd40, 6'd40, 1'b0, 16'hFFFE);
  endtask

  // Requests cluster in a small moving window so spins interact.
  task automatic test_random_sweeps(int count);
    logic [COORD_W-1:0] base_r;
    logic [COORD_W-1:0] base_c;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] c;
    logic [OP_W-1:0] rq_op;
    logic [FRAC_W-1:0] frac;
    int pick;
    base_r = '0;
    base_c = '0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        base_r = ($urandom_range(0, 3) == 0) ? 6'(62 + $urandom_range(0, 2))
                                             : 6'($urandom_range(0, 63));
        base_c = ($urandom_range(0, 3) == 0) ? 6'(62 + $urandom_range(0, 2))
                                             : 6'($urandom_range(0, 63));
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) rq_op = OP_FLIP;
      else if (pick < 80) rq_op = OP_WRITE;
      else if (pick < 92) rq_op = OP_READ;
      else rq_op = OP_SPARE;
      if ($urandom_range(0, 9) == 0) begin
        r = 6'($urandom_range(0, 63));
        c = 6'($urandom_range(0, 63));
      end else begin
        r = base_r + 6'($urandom_range(0, 3));
        c = base_c + 6'($urandom_range(0, 3));
      end
      case ($urandom_range(0, 3))
        0: frac = 16'(accept_four_model + $urandom_range(0, 2) - 1);
        1: frac = 16'(accept_eight_model + $urandom_range(0, 2) - 1);
        default: frac = 16'($urandom_range(0, 65535));
      endcase
      send_request(rq_op, r, c, 1'($urandom_range(0, 1)), frac);
    end
  endtask

  initial begin
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++) torus_model[i][j] = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_WRITE;
    row = '0;
    col = '0;
    spin_value = 1'b0;
    random_fraction = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ACCEPT_FOUR;
    cfg_data = '0;
    steady_flow = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_cold_start();
    test_energy_levels();
    test_torus_wrap();
    test_threshold_extremes();

    set_thresholds(ACCEPT_FOUR_RST, ACCEPT_EIGHT_RST);
    test_random_sweeps(320);
    set_thresholds(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    steady_flow = 1'b1;
    test_random_sweeps(320);
    steady_flow = 1'b0;
    set_thresholds(16'h0000, 16'h0000);
    test_random_sweeps(320);
    set_thresholds(16'hFFFF, 16'hFFFF);
    test_random_sweeps(320);
    set_thresholds(16'hFFFF, 16'h0000);
    test_random_sweeps(320);
    set_thresholds(16'($urandom_range(20000, 40000)), 16'($urandom_range(1, 8000)));
    test_random_sweeps(320);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d requests, %0d results; flips with dE -8/-4/0/4/8: %0d/%0d/%0d/%0d/%0d",
             requests_seen, results_seen, de_count[0], de_count[1], de_count[2],
             de_count[3], de_count[4]);
    $display("%0d flips accepted, %0d mismatches", flips_accepted, mismatches);
    if (mismatches == 0 && pending_spin_results.size() == 0)
      $display("ising_metropolis_spin_update_test: done, clean");
    else
      $display("ising_metropolis_spin_update_test: done, errors");
    $finish;
  end

endmodule

### ising_metropolis_spin_update.f
design/ims_pkg.sv
design/ims_ram.sv
design/ims_addr.sv
design/ims_eval.sv
design/ising_metropolis_spin_update.sv
tb/ising_metropolis_spin_update_test.sv
